// ===== design/mte_pkg.sv =====
`timescale 1ns / 1ps

package mte_pkg;

	localparam int TICK_W    = 28;
	localparam int NOTE_W    = 7;
	localparam int BPM_W     = 16;
	localparam int BYTE_W    = 8;
	localparam int LEN_W     = 32;
	localparam int DIV_W     = 26;
	localparam int QUO_W     = 24;
	localparam int GRP_W     = 7;
	localparam int CNT_W     = 3;
	localparam int DIVCNT_W  = 5;

	localparam logic [DIV_W-1:0]  TEMPO_DIVIDEND = DIV_W'(60000000);
	localparam logic [BPM_W-1:0]  BPM_MIN        = BPM_W'(4);
	localparam logic [QUO_W-1:0]  QUO_SAT        = 24'hFF_FFFF;
	localparam logic [LEN_W-1:0]  TOTAL_RESET    = LEN_W'(4);
	localparam logic [DIVCNT_W-1:0] DIV_STEPS    = DIVCNT_W'(DIV_W);

	localparam logic [BYTE_W-1:0] CODE_NOTE_ON   = 8'h90;
	localparam logic [BYTE_W-1:0] CODE_PROGRAM   = 8'hC0;
	localparam logic [BYTE_W-1:0] CODE_META      = 8'hFF;
	localparam logic [BYTE_W-1:0] CODE_TEMPO     = 8'h51;
	localparam logic [BYTE_W-1:0] CODE_TEMPO_LEN = 8'h03;
	localparam logic [BYTE_W-1:0] CODE_EOT       = 8'h2F;
	localparam logic [BYTE_W-1:0] CODE_ZERO      = 8'h00;

	typedef enum logic [1:0] {
		ACT_NOTE  = 2'd0,
		ACT_TEMPO = 2'd1,
		ACT_PROG  = 2'd2,
		ACT_END   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_DELTA = 3'b010,
		ST_BODY  = 3'b100
	} state_t;

	typedef struct packed {
		logic             load;
		logic             emit;
		logic             body;
		logic [CNT_W-1:0] idx;
		logic             last;
	} cmd_t;

	typedef struct packed {
		logic             out_free;
		logic             div_done;
		logic             in_is_end;
		logic [1:0]       grp_top;
		action_t          action;
	} sts_t;

	function automatic logic [CNT_W-1:0] body_last(input action_t a);
		logic [CNT_W-1:0] r;
		case (a)
			ACT_NOTE:  r = CNT_W'(2);
			ACT_TEMPO: r = CNT_W'(5);
			ACT_PROG:  r = CNT_W'(1);
			ACT_END:   r = CNT_W'(3);
			default:   r = CNT_W'(3);
		endcase
		return r;
	endfunction

endpackage

// ===== design/mte_if.sv =====
`timescale 1ns / 1ps

interface mte_req_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    action;
	logic [mte_pkg::TICK_W-1:0]    tick;
	logic [mte_pkg::NOTE_W-1:0]    note_number;
	logic [mte_pkg::NOTE_W-1:0]    velocity;
	logic [mte_pkg::BPM_W-1:0]     beats_per_minute;
	logic [mte_pkg::NOTE_W-1:0]    program_req;

	modport source (output valid, action, tick, note_number, velocity, beats_per_minute,
		program_req, input ready);
	modport sink (input valid, action, tick, note_number, velocity, beats_per_minute,
		program_req, output ready);
endinterface

interface mte_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [mte_pkg::BYTE_W-1:0]    out_byte;
	logic                          last_byte;
	logic [mte_pkg::LEN_W-1:0]     track_length;

	modport source (output valid, out_byte, last_byte, track_length, input ready);
	modport sink (input valid, out_byte, last_byte, track_length, output ready);
endinterface

// ===== design/mte_ctrl.sv =====
`timescale 1ns / 1ps

module mte_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  mte_pkg::sts_t           sts,
	output mte_pkg::cmd_t           cmd
);

	mte_pkg::state_t             state_q;
	logic [mte_pkg::CNT_W-1:0]   cnt_q;
	logic                        accept;
	logic                        body_wait;
	logic                        body_end;

	assign in_ready  = (state_q == mte_pkg::ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign body_wait = (sts.action == mte_pkg::ACT_TEMPO) && (cnt_q >= mte_pkg::CNT_W'(3))
		&& !sts.div_done;
	assign body_end  = (cnt_q == mte_pkg::body_last(sts.action));

	always_comb begin
		cmd      = '0;
		cmd.load = accept;
		cmd.idx  = cnt_q;
		case (state_q)
			mte_pkg::ST_DELTA: begin
				cmd.emit = sts.out_free;
			end
			mte_pkg::ST_BODY: begin
				cmd.body = 1'b1;
				cmd.emit = sts.out_free && !body_wait;
				cmd.last = body_end;
			end
			default: begin
				cmd.emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mte_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				mte_pkg::ST_IDLE: begin
					if (accept) begin
						if (sts.in_is_end) begin
							state_q <= mte_pkg::ST_BODY;
							cnt_q   <= '0;
						end else begin
							state_q <= mte_pkg::ST_DELTA;
							cnt_q   <= mte_pkg::CNT_W'(sts.grp_top);
						end
					end
				end
				mte_pkg::ST_DELTA: begin
					if (cmd.emit) begin
						if (cnt_q == '0) begin
							state_q <= mte_pkg::ST_BODY;
						end else begin
							cnt_q <= cnt_q - mte_pkg::CNT_W'(1);
						end
					end
				end
				mte_pkg::ST_BODY: begin
					if (cmd.emit) begin
						if (body_end) begin
							state_q <= mte_pkg::ST_IDLE;
							cnt_q   <= '0;
						end else begin
							cnt_q <= cnt_q + mte_pkg::CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= mte_pkg::ST_IDLE;
					cnt_q   <= '0;
				end
			endcase
		end
	end

endmodule

// ===== design/mte_dp.sv =====
`timescale 1ns / 1ps

module mte_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [1:0]                    action,
	input  logic [mte_pkg::TICK_W-1:0]    tick,
	input  logic [mte_pkg::NOTE_W-1:0]    note_number,
	input  logic [mte_pkg::NOTE_W-1:0]    velocity,
	input  logic [mte_pkg::BPM_W-1:0]     beats_per_minute,
	input  logic [mte_pkg::NOTE_W-1:0]    program_req,
	input  mte_pkg::cmd_t                 cmd,
	output mte_pkg::sts_t                 sts,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [mte_pkg::BYTE_W-1:0]    out_byte,
	output logic                          last_byte,
	output logic [mte_pkg::LEN_W-1:0]     track_length
);

	mte_pkg::action_t                 action_q;
	logic [mte_pkg::TICK_W-1:0]       prev_tick_q;
	logic [mte_pkg::TICK_W-1:0]       delta_q;
	logic [mte_pkg::NOTE_W-1:0]       note_q;
	logic [mte_pkg::NOTE_W-1:0]       vel_q;
	logic [mte_pkg::NOTE_W-1:0]       prog_q;
	logic [mte_pkg::BPM_W-1:0]        bpm_q;
	logic [mte_pkg::LEN_W-1:0]        total_q;

	logic [mte_pkg::BPM_W-1:0]        rem_q;
	logic [mte_pkg::DIV_W-1:0]        quo_q;
	logic [mte_pkg::DIVCNT_W-1:0]     div_cnt_q;

	logic                             out_valid_q;
	logic [mte_pkg::BYTE_W-1:0]       out_byte_q;
	logic                             last_q;
	logic [mte_pkg::LEN_W-1:0]        len_q;

	logic [mte_pkg::TICK_W:0]         diff;
	logic [mte_pkg::TICK_W-1:0]       delta_in;
	logic [1:0]                       grp_top;
	logic [mte_pkg::BPM_W:0]          rem_sh;
	logic [mte_pkg::BPM_W:0]          rem_sub;
	logic [mte_pkg::QUO_W-1:0]        tempo_q;
	logic [mte_pkg::GRP_W-1:0]        grp;
	logic [mte_pkg::BYTE_W-1:0]       delta_byte;
	logic [mte_pkg::BYTE_W-1:0]       body_byte;
	logic                             is_end_last;

	assign diff     = {1'b0, tick} - {1'b0, prev_tick_q};
	assign delta_in = diff[mte_pkg::TICK_W] ? '0 : diff[mte_pkg::TICK_W-1:0];

	always_comb begin
		if (delta_in[27:21] != '0) begin
			grp_top = 2'd3;
		end else if (delta_in[20:14] != '0) begin
			grp_top = 2'd2;
		end else if (delta_in[13:7] != '0) begin
			grp_top = 2'd1;
		end else begin
			grp_top = 2'd0;
		end
	end

	assign sts.grp_top   = grp_top;
	assign sts.out_free  = !out_valid_q || out_ready;
	assign sts.div_done  = (div_cnt_q == '0);
	assign sts.in_is_end = (mte_pkg::action_t'(action) == mte_pkg::ACT_END);
	assign sts.action    = action_q;

	assign rem_sh  = {rem_q, quo_q[mte_pkg::DIV_W-1]};
	assign rem_sub = rem_sh - {1'b0, bpm_q};
	assign tempo_q = (bpm_q < mte_pkg::BPM_MIN) ? mte_pkg::QUO_SAT
		: quo_q[mte_pkg::QUO_W-1:0];

	always_comb begin
		case (cmd.idx[1:0])
			2'd0:    grp = delta_q[6:0];
			2'd1:    grp = delta_q[13:7];
			2'd2:    grp = delta_q[20:14];
			2'd3:    grp = delta_q[27:21];
			default: grp = delta_q[6:0];
		endcase
		delta_byte = {(cmd.idx != '0), grp};
	end

	always_comb begin
		body_byte = mte_pkg::CODE_ZERO;
		case (action_q)
			mte_pkg::ACT_NOTE: begin
				case (cmd.idx)
					3'd0:    body_byte = mte_pkg::CODE_NOTE_ON;
					3'd1:    body_byte = {1'b0, note_q};
					default: body_byte = {1'b0, vel_q};
				endcase
			end
			mte_pkg::ACT_TEMPO: begin
				case (cmd.idx)
					3'd0:    body_byte = mte_pkg::CODE_META;
					3'd1:    body_byte = mte_pkg::CODE_TEMPO;
					3'd2:    body_byte = mte_pkg::CODE_TEMPO_LEN;
					3'd3:    body_byte = tempo_q[23:16];
					3'd4:    body_byte = tempo_q[15:8];
					default: body_byte = tempo_q[7:0];
				endcase
			end
			mte_pkg::ACT_PROG: begin
				case (cmd.idx)
					3'd0:    body_byte = mte_pkg::CODE_PROGRAM;
					default: body_byte = {1'b0, prog_q};
				endcase
			end
			default: begin
				case (cmd.idx)
					3'd1:    body_byte = mte_pkg::CODE_META;
					3'd2:    body_byte = mte_pkg::CODE_EOT;
					default: body_byte = mte_pkg::CODE_ZERO;
				endcase
			end
		endcase
	end

	assign is_end_last = cmd.body && cmd.last && (action_q == mte_pkg::ACT_END);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			delta_q <= delta_in;
			note_q  <= note_number;
			vel_q   <= velocity;
			prog_q  <= program_req;
			bpm_q   <= beats_per_minute;
		end
		if (cmd.load) begin
			rem_q <= '0;
			quo_q <= mte_pkg::TEMPO_DIVIDEND;
		end else if (div_cnt_q != '0) begin
			if (!rem_sub[mte_pkg::BPM_W]) begin
				rem_q <= rem_sub[mte_pkg::BPM_W-1:0];
			end else begin
				rem_q <= rem_sh[mte_pkg::BPM_W-1:0];
			end
			quo_q <= {quo_q[mte_pkg::DIV_W-2:0], !rem_sub[mte_pkg::BPM_W]};
		end
		if (cmd.emit) begin
			out_byte_q <= cmd.body ? body_byte : delta_byte;
			last_q     <= cmd.last;
			len_q      <= is_end_last ? total_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			action_q    <= mte_pkg::ACT_NOTE;
			prev_tick_q <= '0;
			total_q     <= mte_pkg::TOTAL_RESET;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				action_q  <= mte_pkg::action_t'(action);
				div_cnt_q <= mte_pkg::DIV_STEPS;
				if (action != mte_pkg::ACT_END) begin
					prev_tick_q <= tick;
				end
			end else if (div_cnt_q != '0) begin
				div_cnt_q <= div_cnt_q - mte_pkg::DIVCNT_W'(1);
			end
			if (cmd.emit) begin
				if (is_end_last) begin
					total_q     <= mte_pkg::TOTAL_RESET;
					prev_tick_q <= '0;
				end else if (action_q != mte_pkg::ACT_END) begin
					total_q <= total_q + mte_pkg::LEN_W'(1);
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign last_byte    = last_q;
	assign track_length = len_q;

endmodule

// ===== design/midi_track_event_encoder.sv =====
// A taken request is registered, then each track byte leaves through the output register, one
// byte a cycle while the output is not held off and, for tempo value bytes, the divider is done.
// Requests: one at a time; a tempo request's value bytes wait for the 26-step bit-serial
// divider for 60000000/bpm. Reset: arst_n clears the previous tick to 0, the byte total to 4
// and empties the output register; no clearing pass is needed.
`timescale 1ns / 1ps

module midi_track_event_encoder (
	input  logic      clk,
	input  logic      arst_n,
	mte_req_if.sink   req,
	mte_rsp_if.source rsp
);

	mte_pkg::cmd_t cmd;
	mte_pkg::sts_t sts;

	mte_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mte_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.action           (req.action),
		.tick             (req.tick),
		.note_number      (req.note_number),
		.velocity         (req.velocity),
		.beats_per_minute (req.beats_per_minute),
		.program_req      (req.program_req),
		.cmd              (cmd),
		.sts              (sts),
		.out_valid        (rsp.valid),
		.out_ready        (rsp.ready),
		.out_byte         (rsp.out_byte),
		.last_byte        (rsp.last_byte),
		.track_length     (rsp.track_length)
	);

endmodule
